>>> hw/rtl/utf8rf_pkg.sv
package utf8rf_pkg;

    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] LEAD2_MASK   = 8'hE0;
    localparam logic [7:0] LEAD2_CODE   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK   = 8'hF0;
    localparam logic [7:0] LEAD3_CODE   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK   = 8'hF8;
    localparam logic [7:0] LEAD4_CODE   = 8'hF0;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_CODE    = 8'h80;
    localparam logic [7:0] REP_BYTE0    = 8'hEF;
    localparam logic [7:0] REP_BYTE1    = 8'hBF;
    localparam logic [7:0] REP_BYTE2    = 8'hBD;
    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_present;
        logic        run_last;
        logic        stream_done;
        logic [15:0] bytes_written;
        logic        any_replaced;
    } out_item_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_HALT,
        CMD_PUT_ASCII,
        CMD_REPLACE,
        CMD_SEQ,
        CMD_PUT_EMIT,
        CMD_FINAL,
        CMD_MARK,
        CMD_FLUSH
    } cmd_t;

    typedef struct packed {
        logic loop_done;
        logic full;
        logic ascii;
        logic bad;
        logic wait_more;
        logic fits_rep;
        logic fits_seq;
        logic eoi;
        logic can_put;
        logic pend_valid;
        logic adv;
        logic emit_last;
    } status_t;

    function automatic logic [2:0] form_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b < ASCII_LIMIT) begin
            len = 3'd1;
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            len = 3'd2;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            len = 3'd3;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

>>> hw/rtl/utf8rf_ctrl.sv
module utf8rf_ctrl
    import utf8rf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_EMIT  = 5'b00100,
        ST_MARK  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (st.loop_done) begin
                    cmd        = CMD_FINAL;
                    state_next = st.eoi ? ST_MARK : ST_FLUSH;
                end else if (st.full) begin
                    cmd = CMD_HALT;
                end else if (st.ascii) begin
                    if (st.can_put) begin
                        cmd = CMD_PUT_ASCII;
                    end
                end else if (st.wait_more) begin
                    cmd        = CMD_FINAL;
                    state_next = ST_FLUSH;
                end else if (st.bad) begin
                    cmd = CMD_REPLACE;
                    if (st.fits_rep) begin
                        state_next = ST_EMIT;
                    end
                end else if (st.fits_seq) begin
                    cmd        = CMD_SEQ;
                    state_next = ST_EMIT;
                end else begin
                    cmd = CMD_HALT;
                end
            end
            ST_EMIT: begin
                if (st.can_put) begin
                    cmd = CMD_PUT_EMIT;
                    if (st.emit_last) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_MARK: begin
                if (st.can_put) begin
                    cmd        = CMD_MARK;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!st.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (st.adv) begin
                    cmd        = CMD_FLUSH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/utf8rf_datapath.sv
module utf8rf_datapath
    import utf8rf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  in_item_t    s_data,
    input  logic        m_ready,
    output logic        m_valid,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  cmd_t        cmd,
    output status_t     st
);

    logic [7:0]  q_reg [4];
    logic [7:0]  q_next [4];
    logic [2:0]  n_reg, n_next;
    logic [15:0] written_reg, written_next;
    logic        halted_reg, halted_next;
    logic        replaced_reg, replaced_next;
    logic        eoi_reg, eoi_next;
    logic [15:0] limit_reg, limit_next;
    logic [1:0]  emit_cnt_reg, emit_cnt_next;
    logic        emit_rep_reg, emit_rep_next;
    out_item_t   pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;
    out_item_t   out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic [2:0]  len;
    logic        cont_bad;
    logic        short;
    logic        adv;
    logic        can_put;
    logic        produce;
    logic        pop;
    out_item_t   new_item;
    logic [7:0]  rep_byte;

    assign len     = form_length(q_reg[0]);
    assign short   = n_reg < len;
    assign adv     = !out_valid_reg || m_ready;
    assign can_put = !pend_valid_reg || adv;

    always_comb begin
        cont_bad = 1'b0;
        for (int j = 1; j < 4; j++) begin
            if ((3'(j) < len) && (3'(j) < n_reg) &&
                ((q_reg[j] & CONT_MASK) != CONT_CODE)) begin
                cont_bad = 1'b1;
            end
        end
    end

    always_comb begin
        case (emit_cnt_reg)
            2'd3:    rep_byte = REP_BYTE0;
            2'd2:    rep_byte = REP_BYTE1;
            default: rep_byte = REP_BYTE2;
        endcase
    end

    always_comb begin
        st.loop_done  = (n_reg == 3'd0) || halted_reg;
        st.full       = written_reg >= limit_reg;
        st.ascii      = len == 3'd1;
        st.bad        = (len == 3'd0) || cont_bad || (short && eoi_reg);
        st.wait_more  = (len != 3'd0) && !cont_bad && short && !eoi_reg;
        st.fits_rep   = ({1'b0, written_reg} + 17'd3) <= {1'b0, limit_reg};
        st.fits_seq   = ({1'b0, written_reg} + {14'd0, len}) <= {1'b0, limit_reg};
        st.eoi        = eoi_reg;
        st.can_put    = can_put;
        st.pend_valid = pend_valid_reg;
        st.adv        = adv;
        st.emit_last  = emit_cnt_reg == 2'd1;
    end

    always_comb begin
        q_next          = q_reg;
        n_next          = n_reg;
        written_next    = written_reg;
        halted_next     = halted_reg;
        replaced_next   = replaced_reg;
        eoi_next        = eoi_reg;
        emit_cnt_next   = emit_cnt_reg;
        emit_rep_next   = emit_rep_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        limit_next      = cfg_we ? cfg_wdata : limit_reg;
        produce         = 1'b0;
        pop             = 1'b0;

        new_item.out_byte      = q_reg[0];
        new_item.byte_present  = 1'b1;
        new_item.run_last      = 1'b0;
        new_item.stream_done   = 1'b0;
        new_item.bytes_written = written_reg + 16'd1;
        new_item.any_replaced  = replaced_reg;

        case (cmd)
            CMD_LOAD: begin
                q_next[n_reg[1:0]] = s_data.in_byte;
                n_next             = n_reg + 3'd1;
                eoi_next           = s_data.end_of_input;
            end
            CMD_HALT: begin
                halted_next = 1'b1;
            end
            CMD_PUT_ASCII: begin
                produce = 1'b1;
                pop     = 1'b1;
            end
            CMD_REPLACE: begin
                replaced_next = 1'b1;
                pop           = 1'b1;
                emit_cnt_next = 2'd3;
                emit_rep_next = 1'b1;
            end
            CMD_SEQ: begin
                emit_cnt_next = len[1:0];
                emit_rep_next = 1'b0;
            end
            CMD_PUT_EMIT: begin
                produce       = 1'b1;
                emit_cnt_next = emit_cnt_reg - 2'd1;
                if (emit_rep_reg) begin
                    new_item.out_byte = rep_byte;
                end else begin
                    pop = 1'b1;
                end
            end
            CMD_FINAL: begin
                if (halted_reg || eoi_reg) begin
                    n_next = 3'd0;
                end
            end
            CMD_MARK: begin
                produce                = 1'b1;
                new_item.out_byte      = 8'd0;
                new_item.byte_present  = 1'b0;
                new_item.stream_done   = 1'b1;
                new_item.bytes_written = written_reg;
                n_next                 = 3'd0;
                halted_next            = 1'b0;
                replaced_next          = 1'b0;
            end
            CMD_FLUSH: begin
                out_next          = pend_reg;
                out_next.run_last = 1'b1;
                out_valid_next    = 1'b1;
                pend_valid_next   = 1'b0;
            end
            default: begin
            end
        endcase

        if (pop) begin
            for (int i = 0; i < 3; i++) begin
                q_next[i] = q_reg[i + 1];
            end
            n_next = n_reg - 3'd1;
        end

        if (cmd != CMD_FLUSH) begin
            if (produce && pend_valid_reg) begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end else if (m_ready) begin
                out_valid_next = 1'b0;
            end
        end

        if (produce) begin
            pend_next       = new_item;
            pend_valid_next = 1'b1;
            written_next    = new_item.bytes_written;
            if (cmd == CMD_MARK) begin
                written_next = 16'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg    <= q_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (!aresetn) begin
            n_reg          <= 3'd0;
            written_reg    <= 16'd0;
            halted_reg     <= 1'b0;
            replaced_reg   <= 1'b0;
            eoi_reg        <= 1'b0;
            limit_reg      <= LIMIT_RESET;
            emit_cnt_reg   <= 2'd0;
            emit_rep_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            n_reg          <= n_next;
            written_reg    <= written_next;
            halted_reg     <= halted_next;
            replaced_reg   <= replaced_next;
            eoi_reg        <= eoi_next;
            limit_reg      <= limit_next;
            emit_cnt_reg   <= emit_cnt_next;
            emit_rep_reg   <= emit_rep_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> hw/rtl/utf8_repair_filter.sv
// UTF-8 repair filter: takes one raw byte per transfer on s_ (end_of_input marks the last
// byte of a stream) and returns repaired bytes on m_, ASCII passed at once, complete
// multi-byte sequences passed whole, bad leads and stray bytes replaced by EF BF BD, and
// every stream closed by a bare done marker carrying the byte count and replacement flag.
// cfg_we/cfg_wdata set the output byte budget (reset 65535); the user must write them only
// between streams, as the block itself does not enforce this. The controller makes one
// decision or sends one result per cycle unless a result waits on m_ready. A byte that is
// only held stays for a later scan, and a byte that arrives once the budget is spent is
// ignored. Every held byte is scanned again after each new byte, a spent budget found
// during a scan halts the scan, the end of a stream adds the done marker, and each cycle
// with m_ready low while a result waits stalls the controller.
module utf8_repair_filter
    import utf8rf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    cmd_t    cmd;
    status_t st;

    utf8rf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    utf8rf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
